FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the uniform LBP filter.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ulbp_pkg.sv
// Package for the uniform LBP 3x3 filter: transaction types, register indexes
// and the 59-bin uniform pattern table. No dependencies.
package ulbp_pkg;

  // Input transaction
  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [5:0] pattern_bin;
    logic [9:0] center_row;
    logic [6:0] center_col;
    logic       frame_last;
  } out_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  localparam int unsigned CFG_DATA_W     = 10;
  localparam logic [7:0]  WIDTH_RESET    = 8'd100;
  localparam logic [9:0]  HEIGHT_RESET   = 10'd130;
  localparam logic [7:0]  WIDTH_MIN      = 8'd3;
  localparam logic [9:0]  HEIGHT_MIN     = 10'd3;
  localparam logic [5:0]  BIN_MAX        = 6'd58;

  typedef logic [5:0] bin_lut_t [0:255];

  // Number of circular 0/1 transitions in an 8-bit code
  function automatic logic [3:0] transitions(input logic [7:0] code);
    logic [7:0] x;
    logic [3:0] n;
    x = code ^ {code[0], code[7:1]};
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(x[i]);
    end
    return n;
  endfunction

  // Uniform codes numbered 1..58 in ascending order, others 0
  function automatic bin_lut_t build_bin_lut();
    bin_lut_t   lut;
    logic [5:0] next;
    next = 6'd1;
    for (int code = 0; code < 256; code++) begin
      if (transitions(8'(code)) <= 4'd2) begin
        lut[code] = next;
        next      = next + 6'd1;
      end else begin
        lut[code] = 6'd0;
      end
    end
    return lut;
  endfunction

  localparam bin_lut_t BIN_LUT = build_bin_lut();

endpackage

FILE: rtl/uniform_lbp_3x3_filter_top.sv
// Top level of the uniform LBP 3x3 filter: line stores, 3x3 window and
// pattern lookup. Depends on ulbp_pkg and assert_macros.svh.
//
// Usage
//   Pixels enter in raster order on in_valid / in_stall / in_data, one
//   transaction per clock when the result side keeps up. in_data.frame_start
//   marks pixel (0,0); otherwise the counters wrap at the configured size.
//   For each interior pixel one result leaves on out_valid / out_stall /
//   out_data, carrying the uniform bin and the centre coordinates; border
//   pixels give no result. frame_last flags the final result of a frame.
//   The result for centre (r-1,c-1) passes stage A and the output register
//   after pixel (r,c) is accepted. Throughput: one pixel per clock when not
//   stalled, set by the single read and single write port of each line store.
//   While the receiver stalls, the result is held in the output register;
//   the block keeps accepting until its one internal stage is also full,
//   then raises in_stall.
//   Reset (rst_n low, synchronous) clears counters, pipeline valids and
//   loads frame_width 100, frame_height 130. Line stores are not cleared.
//   cfg_we writes frame_width (index 0) or frame_height (index 1); write
//   only while the block is idle.
`include "assert_macros.svh"

module uniform_lbp_3x3_filter_top #(
  parameter int MAX_WIDTH = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ulbp_pkg::in_t                    in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output ulbp_pkg::out_t                   out_data,
  // configuration
  input  logic                             cfg_we,
  input  ulbp_pkg::cfg_idx_t               cfg_index,
  input  logic [ulbp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CW  = $clog2(MAX_WIDTH);        // column counter / address
  localparam int WW  = $clog2(MAX_WIDTH + 1);    // width in use
  localparam int XW  = (WW > 8) ? WW : 8;        // width compare
  localparam int CXW = (CW > 7) ? CW : 7;        // centre column arithmetic

  // Configuration registers
  logic [7:0] frame_width_r;
  logic [9:0] frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= ulbp_pkg::WIDTH_RESET;
      frame_height_r <= ulbp_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ulbp_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[7:0];
        ulbp_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[9:0];
        default:                    ;
      endcase
    end
  end

  // Saturated frame size
  logic [XW-1:0] width_x;
  logic [WW-1:0] width_use;
  logic [9:0]    height_use;

  always_comb begin
    width_x = XW'(frame_width_r);
    if (frame_width_r < ulbp_pkg::WIDTH_MIN) begin
      width_use = WW'(ulbp_pkg::WIDTH_MIN);
    end else if (width_x > XW'(MAX_WIDTH)) begin
      width_use = WW'(MAX_WIDTH);
    end else begin
      width_use = WW'(width_x);
    end
    height_use = (frame_height_r < ulbp_pkg::HEIGHT_MIN) ? ulbp_pkg::HEIGHT_MIN
                                                         : frame_height_r;
  end

  // Handshake control
  logic in_fire, b_fire;
  logic a_valid_r, out_valid_r;
  ulbp_pkg::out_t out_data_r;

  assign b_fire    = a_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = a_valid_r && !b_fire;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Stage A: position counters
  logic [CW-1:0] col_r, col_nxt, col_cur;
  logic [9:0]    row_r, row_nxt, row_cur;

  always_comb begin
    col_cur = in_data.frame_start ? '0 : col_r;
    row_cur = in_data.frame_start ? '0 : row_r;
    if (WW'(col_cur) + WW'(1) >= width_use) begin
      col_nxt = '0;
      row_nxt = ({1'b0, row_cur} + 11'd1 >= {1'b0, height_use}) ? '0 : row_cur + 10'd1;
    end else begin
      col_nxt = col_cur + CW'(1);
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line stores: one read and one write port each, registered read
  logic [7:0]    upper_mem [MAX_WIDTH];
  logic [7:0]    middle_mem [MAX_WIDTH];
  logic [7:0]    a_top_rd_r, a_mid_rd_r, a_pix_r, a_fwd_mid_r;
  logic [CW-1:0] a_col_r;
  logic [9:0]    a_row_r;
  logic          a_fwd_r;
  logic [7:0]    top_eff;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_top_rd_r         <= upper_mem[col_cur];
      a_mid_rd_r         <= middle_mem[col_cur];
      middle_mem[col_cur] <= in_data.pixel;
      a_pix_r            <= in_data.pixel;
      a_col_r            <= col_cur;
      a_row_r            <= row_cur;
      // the item ahead writes the upper store at this same address now
      a_fwd_r            <= a_valid_r && (a_col_r == col_cur);
      a_fwd_mid_r        <= a_mid_rd_r;
    end
    if (b_fire) begin
      upper_mem[a_col_r] <= a_mid_rd_r;
    end
  end

  assign top_eff = a_fwd_r ? a_fwd_mid_r : a_top_rd_r;

  // Stage B: window, comparisons and bin lookup
  logic [7:0]     win_r [6];  // [0..2] column c-2, [3..5] column c-1
  logic [7:0]     centre, code;
  logic           has_result;
  logic [CXW-1:0] col_m1;
  ulbp_pkg::out_t res;

  always_comb begin
    centre  = win_r[4];
    code[0] = win_r[1] >= centre;  // left
    code[1] = win_r[2] >= centre;  // bottom-left
    code[2] = win_r[5] >= centre;  // bottom
    code[3] = a_pix_r  >= centre;  // bottom-right
    code[4] = a_mid_rd_r >= centre; // right
    code[5] = top_eff  >= centre;  // top-right
    code[6] = win_r[3] >= centre;  // top
    code[7] = win_r[0] >= centre;  // top-left
    has_result = (a_col_r >= CW'(2)) && (a_row_r >= 10'd2) &&
                 (WW'(a_col_r) < width_use) && (a_row_r < height_use);
    col_m1 = CXW'(a_col_r) - CXW'(1);
    res.pattern_bin = ulbp_pkg::BIN_LUT[code];
    res.center_row  = a_row_r - 10'd1;
    res.center_col  = col_m1[6:0];
    res.frame_last  = (a_row_r == height_use - 10'd1) &&
                      (WW'(a_col_r) == width_use - WW'(1));
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_eff;
      win_r[4] <= a_mid_rd_r;
      win_r[5] <= a_pix_r;
      out_data_r <= res;
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        a_valid_r <= 1'b1;
      end else if (b_fire) begin
        a_valid_r <= 1'b0;
      end
      if (b_fire) begin
        out_valid_r <= has_result;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Assertions
  `LBP_ASSERT_IMP(a_no_overrun, in_fire, !a_valid_r || b_fire,
                  "stage A overwritten before it moved on")
  `LBP_ASSERT_IMP(a_bin_range, out_valid_r, out_data_r.pattern_bin <= ulbp_pkg::BIN_MAX,
                  "pattern bin out of range")
  `LBP_ASSERT_IMP(a_last_pos, out_valid_r && out_data_r.frame_last,
                  (out_data_r.center_row == height_use - 10'd2) &&
                  (WW'(out_data_r.center_col) == width_use - WW'(2)),
                  "frame_last not at last interior pixel")

endmodule

FILE: dv/uniform_lbp_3x3_filter_top_test.sv
// Self-checking testbench for the uniform LBP 3x3 filter: a software model of
// the line stores and window predicts each bin and centre position.
// Depends on ulbp_pkg and uniform_lbp_3x3_filter_top.
`timescale 1ns / 1ps

module uniform_lbp_3x3_filter_top_test;

  localparam int LINE_DEPTH    = 128;
  localparam int DRAIN_SLACK   = 4;     // pipeline is two stages deep
  localparam int QUIET_LIMIT   = 2000;  // cycles without any transaction
  localparam int RANDOM_PIXELS = 200;

  // Pixel content styles for generated frames
  typedef enum int {
    PIX_NOISE,
    PIX_NEAR,
    PIX_BINARY,
    PIX_FLAT
  } pix_mode_t;

  logic                ulbp_pkg_dummy_unused_never;
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  ulbp_pkg::in_t       in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ulbp_pkg::out_t      out_data;
  logic                cfg_we    = 1'b0;
  ulbp_pkg::cfg_idx_t  cfg_index = ulbp_pkg::CFG_FRAME_WIDTH;
  logic [ulbp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  bit        idle_enabled = 1'b1;
  int        mismatch_count = 0;
  int        quiet_cycles = 0;

  // Model state
  logic [5:0]     uniform_bin [256];
  logic [7:0]     upper_row [LINE_DEPTH];
  logic [7:0]     middle_row [LINE_DEPTH];
  logic [7:0]     win [6];          // [0..2] column c-2, [3..5] column c-1
  int             col_pos;
  int             row_pos;
  logic [7:0]     frame_width_cfg;
  logic [9:0]     frame_height_cfg;
  ulbp_pkg::out_t pending_patterns [$];
  ulbp_pkg::out_t oldest;

  uniform_lbp_3x3_filter_top #(
    .MAX_WIDTH (LINE_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Register values as the block uses them
  function automatic int used_width(input logic [7:0] v);
    int w;
    w = v;
    if (w < 3) w = 3;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic int used_height(input logic [9:0] v);
    int h;
    h = v;
    if (h < 3) h = 3;
    return h;
  endfunction

  function automatic logic [7:0] draw_pixel(input pix_mode_t mode, input logic [7:0] level);
    case (mode)
      PIX_NOISE:  return 8'($urandom);
      PIX_NEAR:   return level + 8'($urandom_range(0, 2)) - 8'd1;
      PIX_BINARY: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      default:    return level;
    endcase
  endfunction

  // Slide the model window by one pixel, queueing a result for interior centres
  task automatic advance_window(input ulbp_pkg::in_t item);
    int             w;
    int             h;
    int             c;
    int             r;
    logic [7:0]     top;
    logic [7:0]     mid;
    logic [7:0]     ctr;
    logic [7:0]     code;
    ulbp_pkg::out_t res;
    w = used_width(frame_width_cfg);
    h = used_height(frame_height_cfg);
    if (item.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    top = upper_row[c];
    mid = middle_row[c];
    upper_row[c]  = mid;
    middle_row[c] = item.pixel;
    if (c >= 2 && r >= 2 && c < w && r < h) begin
      ctr  = win[4];
      // bit 7 top-left down to bit 0 left
      code = {win[0] >= ctr, win[3] >= ctr, top >= ctr, mid >= ctr,
              item.pixel >= ctr, win[5] >= ctr, win[2] >= ctr, win[1] >= ctr};
      res.pattern_bin = uniform_bin[code];
      res.center_row  = 10'(r - 1);
      res.center_col  = 7'(c - 1);
      res.frame_last  = (r == h - 1) && (c == w - 1);
      pending_patterns = {pending_patterns, res};
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = item.pixel;
    // raster counters with wrap at the sizes in use
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Track register writes and accepted pixels
  always @(posedge clk) begin
    if (!rst_n) begin
      col_pos          = 0;
      row_pos          = 0;
      frame_width_cfg  = ulbp_pkg::WIDTH_RESET;
      frame_height_cfg = ulbp_pkg::HEIGHT_RESET;
      pending_patterns.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ulbp_pkg::CFG_FRAME_WIDTH:  frame_width_cfg  = cfg_wdata[7:0];
          ulbp_pkg::CFG_FRAME_HEIGHT: frame_height_cfg = cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) advance_window(in_data);
    end
  end

  task automatic log_fault(input string msg);
    if (mismatch_count < 10) $display("%0t ERROR: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_patterns.size() == 0) begin
        log_fault($sformatf("unexpected result bin=%0d row=%0d col=%0d last=%0b",
                            out_data.pattern_bin, out_data.center_row,
                            out_data.center_col, out_data.frame_last));
      end else begin
        oldest = pending_patterns.pop_front();
        if (out_data.pattern_bin !== oldest.pattern_bin ||
            out_data.center_row !== oldest.center_row ||
            out_data.center_col !== oldest.center_col ||
            out_data.frame_last !== oldest.frame_last) begin
          log_fault($sformatf({"exp bin=%0d row=%0d col=%0d last=%0b, ",
                               "got bin=%0d row=%0d col=%0d last=%0b"},
                              oldest.pattern_bin, oldest.center_row,
                              oldest.center_col, oldest.frame_last,
                              out_data.pattern_bin, out_data.center_row,
                              out_data.center_col, out_data.frame_last));
        end
      end
    end
  end

  // Receiver back-pressure in bursts
  always begin
    @(posedge clk);
    if (idle_enabled && $urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // One pixel transaction, with an optional source gap in front
  task automatic send_pixel(input logic [7:0] pix, input bit start);
    if (idle_enabled && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {pix, start};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // A run of generated pixels; stray frame marks break sequences on request
  task automatic send_run(input int count, input bit mark_start, input bit allow_stray);
    pix_mode_t  mode;
    logic [7:0] level;
    int         pick;
    bit         start;
    pick  = $urandom_range(0, 9);
    mode  = (pick < 4) ? PIX_NOISE : (pick < 7) ? PIX_NEAR : (pick < 9) ? PIX_BINARY : PIX_FLAT;
    level = 8'($urandom);
    for (int i = 0; i < count; i++) begin
      start = (i == 0) ? mark_start : (allow_stray && $urandom_range(0, 199) == 0);
      send_pixel(draw_pixel(mode, level), start);
    end
  endtask

  // Stop the source, let every result out, then allow the pipe to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_patterns.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input ulbp_pkg::cfg_idx_t idx,
                           input logic [ulbp_pkg::CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Reset sizes, counters starting at zero without a frame mark
  task automatic test_reset_geometry();
    send_run(2 * int'(ulbp_pkg::WIDTH_RESET) + 20, 1'b0, 1'b0);
  endtask

  // Smallest frame: ties, extremes and a non-uniform code, frames chained by wrap
  task automatic test_corner_patterns();
    logic [7:0] corner_px [27];
    corner_px = '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
                  8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
                  8'd0,   8'd255, 8'd0,   8'd255, 8'd128, 8'd255, 8'd0,   8'd255, 8'd0};
    write_reg(ulbp_pkg::CFG_FRAME_WIDTH, 10'd3);
    write_reg(ulbp_pkg::CFG_FRAME_HEIGHT, 10'd3);
    for (int i = 0; i < 27; i++) send_pixel(corner_px[i], i == 0);
  endtask

  // Out-of-range sizes saturate to 3 and to the line depth
  task automatic test_size_saturation();
    write_reg(ulbp_pkg::CFG_FRAME_WIDTH, 10'd0);
    write_reg(ulbp_pkg::CFG_FRAME_HEIGHT, 10'd2);
    send_run(9, 1'b1, 1'b0);
    write_reg(ulbp_pkg::CFG_FRAME_WIDTH, 10'd255);
    write_reg(ulbp_pkg::CFG_FRAME_HEIGHT, 10'd0);
    send_run(3 * LINE_DEPTH, 1'b1, 1'b0);
  endtask

  // Tallest height, first rows of it only
  task automatic test_tall_frame();
    write_reg(ulbp_pkg::CFG_FRAME_WIDTH, 10'd3);
    write_reg(ulbp_pkg::CFG_FRAME_HEIGHT, 10'd1023);
    send_run(3 * 40, 1'b1, 1'b0);
  endtask

  // Shrink width, then height, while the counters sit beyond the new limit
  task automatic test_midframe_resize();
    write_reg(ulbp_pkg::CFG_FRAME_WIDTH, 10'd10);
    write_reg(ulbp_pkg::CFG_FRAME_HEIGHT, 10'd10);
    send_run(37, 1'b1, 1'b0);
    write_reg(ulbp_pkg::CFG_FRAME_WIDTH, 10'd5);
    send_run(13, 1'b0, 1'b0);
    write_reg(ulbp_pkg::CFG_FRAME_HEIGHT, 10'd4);
    send_run(23, 1'b0, 1'b0);
  endtask

  // Random sizes and content, chained or marked frames, some cut short
  task automatic test_random_stream(input int budget);
    int         sent;
    int         pick;
    int         w;
    int         h;
    int         frames;
    int         count;
    logic [7:0] wr;
    logic [9:0] hr;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          wr = 8'd128;
          hr = 10'($urandom_range(3, 4));
        end
        1: begin
          wr = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(129, 255));
          hr = 10'($urandom_range(0, 6));
        end
        2: begin
          wr = 8'($urandom_range(3, 5));
          hr = 10'd1023;
        end
        default: begin
          wr = 8'($urandom_range(3, 16));
          hr = 10'($urandom_range(3, 12));
        end
      endcase
      write_reg(ulbp_pkg::CFG_FRAME_WIDTH, {2'b00, wr});
      write_reg(ulbp_pkg::CFG_FRAME_HEIGHT, hr);
      w      = used_width(wr);
      h      = used_height(hr);
      frames = (pick == 0) ? 1 : $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        if (pick == 2) count = w * $urandom_range(3, 40);
        else if ($urandom_range(0, 9) == 0) count = $urandom_range(1, w * h);
        else count = w * h;
        send_run(count, (f == 0) || ($urandom_range(0, 1) == 1), 1'b1);
        sent += count;
      end
    end
  endtask

  // Full rate on both sides
  task automatic test_full_rate();
    idle_enabled = 1'b0;
    write_reg(ulbp_pkg::CFG_FRAME_WIDTH, 10'd16);
    write_reg(ulbp_pkg::CFG_FRAME_HEIGHT, 10'd8);
    send_run(128, 1'b1, 1'b0);
    send_run(128, 1'b0, 1'b0);
  endtask

  initial begin
    int         next_bin;
    int         flips;
    logic [7:0] cb;
    // uniform codes numbered in ascending order
    next_bin = 1;
    for (int code = 0; code < 256; code++) begin
      cb    = 8'(code);
      flips = 0;
      for (int i = 0; i < 8; i++) if (cb[i] != cb[(i + 1) % 8]) flips++;
      uniform_bin[code] = (flips <= 2) ? 6'(next_bin) : 6'd0;
      if (flips <= 2) next_bin++;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_geometry();
    test_corner_patterns();
    test_size_saturation();
    test_tall_frame();
    test_midframe_resize();
    test_random_stream(RANDOM_PIXELS);
    test_full_rate();

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
